>>> rtl/xwkc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xwkc_pkg
// Shared constants and the XOR-window state map of the keystream cipher.
// ----------------------------------------------------------------------------
package xwkc_pkg;

  localparam int unsigned MAX_KEY_WIDTH = 64;
  localparam int unsigned KEY_WIDTH_DEF = 64;
  localparam int unsigned BYTE_BITS     = 8;

  // Taps of output bit o of the map: a window of state bits, less the
  // centre bit when the window length is odd.
  function automatic logic [MAX_KEY_WIDTH-1:0] row_mask(input int unsigned k,
                                                        input int unsigned o);
    int unsigned start;
    int unsigned col;
    int unsigned left;
    int unsigned right;
    int unsigned len;
    logic [MAX_KEY_WIDTH-1:0] m;
    start = (k - 1) - (k >> 1);
    col   = start + o;
    if (col <= k - 1) begin
      left  = k - 1 - col;
      right = k - 1;
    end else begin
      left  = 0;
      right = 2 * k - 2 - col;
    end
    len = right - left + 1;
    m = '0;
    for (int unsigned b = 0; b < MAX_KEY_WIDTH; b++) begin
      if (b >= left && b <= right) begin
        m[b] = 1'b1;
      end
    end
    if (len[0]) begin
      m[left + (len >> 1)] = 1'b0;
    end
    return m;
  endfunction

  // One application of the map to a k-bit state held in the low bits.
  function automatic logic [MAX_KEY_WIDTH-1:0] win_map(
    input logic [MAX_KEY_WIDTH-1:0] s,
    input int unsigned              k
  );
    logic [MAX_KEY_WIDTH-1:0] r;
    r = '0;
    for (int unsigned o = 0; o < MAX_KEY_WIDTH; o++) begin
      if (o < k) begin
        r[o] = ^(s & row_mask(k, o));
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/xor_window_keystream_cipher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xor_window_keystream_cipher_top
// Byte-wide XOR-window keystream cipher; encryption and decryption are the
// same operation.
// ----------------------------------------------------------------------------
// The block takes one data beat per clock while in_stall is low and puts its
// result in the output register; a new beat is taken whenever that register is
// empty or is being emptied in the same cycle. A beat with restart set loads
// the state from the seed register and starts a fresh keystream. The seed may
// be written at any time and is used only at the next restart. The cycle time
// is set by the XOR-window map: when KEY_WIDTH is below eight, one byte can
// need two map steps back to back, otherwise at most one, followed by the
// selection of eight keystream bits.
module xor_window_keystream_cipher_top #(
  parameter int unsigned KEY_WIDTH = xwkc_pkg::KEY_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte
);

  localparam int unsigned PW = $clog2(KEY_WIDTH + 1);
  localparam int unsigned CW = $clog2(2 * KEY_WIDTH + xwkc_pkg::BYTE_BITS + 1);
  localparam int unsigned IW = $clog2(KEY_WIDTH);
  localparam int unsigned MW = xwkc_pkg::MAX_KEY_WIDTH;

  logic [63:0]          seed_r;
  logic [KEY_WIDTH-1:0] state_r;
  logic [KEY_WIDTH-1:0] state_nxt;
  logic [PW-1:0]        bit_pos_r;
  logic [PW-1:0]        bit_pos_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic [7:0]           out_byte_nxt;
  logic                 accept;

  logic [KEY_WIDTH-1:0] s0;
  logic [KEY_WIDTH-1:0] m1;
  logic [KEY_WIDTH-1:0] m2;
  logic [MW-1:0]        m1_full;
  logic [MW-1:0]        m2_full;
  logic [PW-1:0]        p0;
  logic [CW-1:0]        p_end;
  logic [7:0]           ks;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign s0 = in_restart ? seed_r[KEY_WIDTH-1:0] : state_r;
  assign p0 = in_restart ? PW'(KEY_WIDTH) : bit_pos_r;

  assign m1_full = xwkc_pkg::win_map(MW'(s0), KEY_WIDTH);
  assign m1      = m1_full[KEY_WIDTH-1:0];
  assign m2_full = xwkc_pkg::win_map(MW'(m1), KEY_WIDTH);
  assign m2      = m2_full[KEY_WIDTH-1:0];

  assign p_end = CW'(p0) + CW'(xwkc_pkg::BYTE_BITS);

  // Each keystream bit comes from the current block, the next one, or (for
  // small keys) the one after that.
  always_comb begin
    logic [CW-1:0] q;
    logic [CW-1:0] d;
    ks = '0;
    for (int unsigned i = 0; i < xwkc_pkg::BYTE_BITS; i++) begin
      q = CW'(p0) + CW'(i);
      d = '0;
      if (q < CW'(KEY_WIDTH)) begin
        ks[i] = s0[q[IW-1:0]];
      end else if (q < CW'(2 * KEY_WIDTH)) begin
        d = q - CW'(KEY_WIDTH);
        ks[i] = m1[d[IW-1:0]];
      end else begin
        d = q - CW'(2 * KEY_WIDTH);
        ks[i] = m2[d[IW-1:0]];
      end
    end
  end

  always_comb begin
    logic [CW-1:0] rem;
    if (p_end > CW'(2 * KEY_WIDTH)) begin
      rem       = p_end - CW'(2 * KEY_WIDTH);
      state_nxt = m2;
    end else if (p_end > CW'(KEY_WIDTH)) begin
      rem       = p_end - CW'(KEY_WIDTH);
      state_nxt = m1;
    end else begin
      rem       = p_end;
      state_nxt = s0;
    end
    bit_pos_nxt  = rem[PW-1:0];
    out_byte_nxt = in_data_byte ^ ks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      state_r     <= '0;
      bit_pos_r   <= PW'(KEY_WIDTH);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (accept) begin
        state_r     <= state_nxt;
        bit_pos_r   <= bit_pos_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= out_byte_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat did not reach the output register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_pos_r <= PW'(KEY_WIDTH))
    else $error("bit position beyond the block");

  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (KEY_WIDTH >= xwkc_pkg::BYTE_BITS) && accept && in_restart
      |=> bit_pos_r == PW'(xwkc_pkg::BYTE_BITS))
    else $error("restart did not leave one byte used of the fresh block");

  a_rise_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(accept))
    else $error("output became valid without an accepted beat");
`endif

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XOR-window keystream cipher. The seed register
// is written between messages; a local model of the map and of the keystream
// position predicts every output byte, and a scoreboard compares the results
// in order. Sender bursts, receiver stalls and a long receiver hold-off
// exercise the valid/stall handshake on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned KW          = xwkc_pkg::KEY_WIDTH_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          BEAT_TARGET = 1050;
  localparam int          HOLD_CYCLES = 40;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_restart  = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  out_byte;

  // Keystream predictor and the queue of cipher bytes still to come.
  class keystream_checker;
    logic [63:0] seed_val;
    logic [63:0] key_state;
    int unsigned key_pos;
    logic [7:0]  pending_cipher_bytes[$];
    int          err_count;
    int          bytes_checked;

    function new();
      seed_val      = '0;
      key_state     = '0;
      key_pos       = KW;
      err_count     = 0;
      bytes_checked = 0;
    endfunction

    function logic [63:0] key_mask();
      return (KW >= 64) ? '1 : ((64'd1 << KW) - 64'd1);
    endfunction

    // One application of the XOR-window map to the state.
    function logic [63:0] step_map(logic [63:0] s);
      int unsigned first_col;
      int unsigned col;
      int unsigned lo;
      int unsigned hi;
      int unsigned span;
      logic [63:0] r;
      logic        acc;
      first_col = (KW - 1) - KW / 2;
      r = '0;
      for (int unsigned o = 0; o < KW; o++) begin
        col = first_col + o;
        if (col <= KW - 1) begin
          lo = KW - 1 - col;
          hi = KW - 1;
        end else begin
          lo = 0;
          hi = 2 * KW - 2 - col;
        end
        span = hi - lo + 1;
        acc = 1'b0;
        for (int unsigned b = lo; b <= hi; b++) acc ^= s[b];
        // An odd-length window leaves out its centre bit.
        if (span % 2 == 1) acc ^= s[lo + span / 2];
        r[o] = acc;
      end
      return r & key_mask();
    endfunction

    function void note_byte_in(logic [7:0] d, logic rs);
      logic [7:0] ks;
      if (rs) begin
        key_state = seed_val & key_mask();
        key_pos   = KW;
      end
      ks = '0;
      for (int i = 0; i < 8; i++) begin
        if (key_pos >= KW) begin
          key_state = step_map(key_state);
          key_pos   = 0;
        end
        ks[i] = key_state[key_pos];
        key_pos++;
      end
      pending_cipher_bytes = {pending_cipher_bytes, d ^ ks};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      err_count++;
    endtask

    task check_byte_out(logic [7:0] got);
      logic [7:0] want;
      if (pending_cipher_bytes.size() == 0) begin
        report($sformatf("out_byte 0x%02h arrived with no byte expected", got));
      end else begin
        want = pending_cipher_bytes.pop_front();
        bytes_checked++;
        if (got !== want)
          report($sformatf("out_byte 0x%02h, expected 0x%02h (byte %0d)",
                           got, want, bytes_checked));
      end
    endtask

    function int pending();
      return pending_cipher_bytes.size();
    endfunction
  endclass

  keystream_checker sb;

  int cycle_count = 0;
  int beats_sent  = 0;
  int restarts    = 0;
  int seeds_set   = 0;
  int burst_left  = 0;
  bit no_gaps     = 1'b0;
  int hold_asked  = 0;
  int hold_served = 0;

  xor_window_keystream_cipher_top #(
    .KEY_WIDTH(KW)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes outstanding", cycle_count, sb.pending());
      $display("** xor_window_keystream_cipher_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte_out(out_byte);
  end

  // Receiver: stall pattern that changes character at random intervals, plus a
  // long hold-off whenever the stimulus asks for one.
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= mode_left[2];
        endcase
      end
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(logic [7:0] d, logic rs);
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_restart   <= rs;
    do @(posedge clk); while (in_stall);
    sb.note_byte_in(d, rs);
    beats_sent++;
    if (rs) restarts++;
  endtask

  // Sends one beat inside the burst/gap pattern of the sender.
  task automatic send_item(logic [7:0] d, logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    send_beat(d, rs);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.seed_val = v;
    seeds_set++;
  endtask

  task automatic run_phase(int idx);
    logic [63:0] s;
    int n_msgs;
    int len;
    bit carry_on;
    logic rs;
    case ($urandom_range(0, 5))
      0: s = '0;
      1: s = '1;
      2: s = 64'd1 << $urandom_range(0, 63);
      3: s = 64'h8000_0000_0000_0001;
      default: s = {$urandom, $urandom};
    endcase
    write_seed(s);
    // Every seventh phase runs without gaps against a long receiver hold-off.
    no_gaps = (idx % 7 == 3);
    if (no_gaps) hold_asked++;
    // Sometimes the first message carries on the old keystream.
    carry_on = ($urandom_range(0, 4) == 0);
    n_msgs = $urandom_range(1, 4);
    for (int m = 0; m < n_msgs; m++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      for (int j = 0; j < len; j++) begin
        rs = ((j == 0) && !(m == 0 && carry_on)) || ($urandom_range(0, 39) == 0);
        send_item(8'($urandom_range(0, 255)), rs);
      end
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With no restart since reset the keystream is all zeros.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h5A, 1'b0);
    drain();

    // All-ones seed, long enough to need a second map step.
    write_seed('1);
    send_beat(8'h00, 1'b1);
    for (int i = 0; i < 9; i++) send_beat((i % 2 == 0) ? 8'hFF : 8'h01 << i, 1'b0);
    drain();

    // Zero seed maps to zero.
    write_seed('0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h80, 1'b0);
    drain();

    // A new seed has no effect until the next restart; back-to-back restarts.
    write_seed(64'h0123_4567_89AB_CDEF);
    send_beat(8'h01, 1'b0);
    send_beat(8'hC3, 1'b1);
    send_beat(8'h3C, 1'b1);
    send_beat(8'h7F, 1'b0);
    drain();

    phase = 0;
    while (beats_sent < BEAT_TARGET) begin
      run_phase(phase);
      phase++;
    end

    drain();
    repeat (5) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected bytes never arrived", sb.pending()));
    $display("Covered %0d beats (%0d with restart) over %0d seed settings.",
             beats_sent, restarts, seeds_set);
    $display("Checked %0d output bytes; %0d mismatches.", sb.bytes_checked, sb.err_count);
    if (sb.err_count == 0)
      $display("** xor_window_keystream_cipher_top: PASSED **");
    else
      $display("** xor_window_keystream_cipher_top: FAILED **");
    $finish;
  end

endmodule

>>> xor_window_keystream_cipher_top.f
rtl/xwkc_pkg.sv
rtl/xor_window_keystream_cipher_top.sv
dv/tb_top.sv
